// ===== src/pva_pkg.sv =====
// Shared constants, codes, result-write struct and helpers of the voice allocator.
package pva_pkg;

  localparam int VOICES_DEF = 8;
  localparam int MAXR       = 8;
  localparam int DIV_W      = 15;
  localparam int GT_W       = 12;

  localparam logic [1:0] OP_ON  = 2'd0;
  localparam logic [1:0] OP_OFF = 2'd1;
  localparam logic [1:0] OP_SUS = 2'd2;
  localparam logic [1:0] OP_ALL = 2'd3;

  localparam logic [1:0] ACT_GLIDE = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  localparam logic [3:0] ADDR_PORTA  = 4'd0;
  localparam logic [3:0] ADDR_GTIME  = 4'd4;
  localparam logic [3:0] ADDR_VSCALE = 4'd8;

  typedef struct packed {
    logic       we;
    logic [1:0] action;
    logic [2:0] voice;
    logic [6:0] note;
    logic [6:0] vel;
    logic [8:0] decay;
  } rb_wr_t;

  // floor(v*256/127) = 2v + floor(2v/127), clamped to 204..256
  function automatic logic [8:0] decay_of(input logic [6:0] v);
    logic [8:0] d2;
    logic [8:0] d;
    d2 = {1'b0, v, 1'b0};
    if (d2 >= 9'd254) d = d2 + 9'd2;
    else if (d2 >= 9'd127) d = d2 + 9'd1;
    else d = d2;
    if (d < 9'd204) d = 9'd204;
    if (d > 9'd256) d = 9'd256;
    return d;
  endfunction

endpackage

// ===== src/pva_div.sv =====
// Restoring divider, one quotient bit per cycle, for the glide step.
module pva_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pva_pkg::DIV_W-1:0]   dividend,
  input  logic [pva_pkg::GT_W-1:0]    divisor,
  output logic                        busy,
  output logic                        done,
  output logic [pva_pkg::DIV_W-1:0]   quo
);

  logic [pva_pkg::GT_W-1:0]  rem;
  logic [pva_pkg::GT_W:0]    sh;
  logic [3:0]                cnt;

  assign sh = {rem, quo[pva_pkg::DIV_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 4'(pva_pkg::DIV_W);
        rem  <= '0;
        quo  <= dividend;
      end else if (busy) begin
        if (sh >= {1'b0, divisor}) begin
          rem <= pva_pkg::GT_W'(sh - {1'b0, divisor});
          quo <= {quo[pva_pkg::DIV_W-2:0], 1'b1};
        end else begin
          rem <= sh[pva_pkg::GT_W-1:0];
          quo <= {quo[pva_pkg::DIV_W-2:0], 1'b0};
        end
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/pva_rbuf.sv =====
// Result buffer: collects the words of one event, then streams them out.
module pva_rbuf (
  input  logic            clk,
  input  logic            rst,
  input  pva_pkg::rb_wr_t wr,
  input  logic            start,
  output logic            busy,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      action,
  output logic [2:0]      voice,
  output logic [6:0]      voice_note,
  output logic [6:0]      voice_velocity,
  output logic [8:0]      decay_scale,
  output logic            last
);

  localparam int PW = $clog2(pva_pkg::MAXR);
  localparam int CW = $clog2(pva_pkg::MAXR + 1);

  pva_pkg::rb_wr_t ent [pva_pkg::MAXR];
  logic [CW-1:0]   wcnt;
  logic [PW-1:0]   rptr;

  assign busy           = out_valid;
  assign action         = ent[rptr].action;
  assign voice          = ent[rptr].voice;
  assign voice_note     = ent[rptr].note;
  assign voice_velocity = ent[rptr].vel;
  assign decay_scale    = ent[rptr].decay;
  assign last           = ({1'b0, rptr} == CW'(wcnt - CW'(1)));

  always_ff @(posedge clk) begin
    if (rst) begin
      wcnt      <= '0;
      rptr      <= '0;
      out_valid <= 1'b0;
    end else begin
      // drop words past the cap
      if (wr.we && wcnt < CW'(pva_pkg::MAXR)) begin
        ent[wcnt[PW-1:0]] <= wr;
        wcnt <= wcnt + CW'(1);
      end
      if (start && wcnt != '0) out_valid <= 1'b1;
      if (out_valid && out_ready) begin
        if (last) begin
          out_valid <= 1'b0;
          wcnt      <= '0;
          rptr      <= '0;
        end else begin
          rptr <= rptr + PW'(1);
        end
      end
    end
  end

endmodule

// ===== src/poly_voice_allocator_core.sv =====
// Voice allocator top: stacks, voice table, scan sequencer, config port.
// Each stack or voice scan walks one entry per cycle; the stack searches and the voice-note
// search go through the shared compare unit, and a glide step other than a jump waits on the
// divider. Results then stream one word per cycle while out_ready is high; the next event
// is taken once the last word is gone.
// Reset (rst, synchronous): stacks empty, all voices idle, sustain off, glide empty.
module poly_voice_allocator_core #(
  parameter int VOICES = pva_pkg::VOICES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        op,
  input  logic [6:0]        note,
  input  logic [6:0]        velocity,
  input  logic              pedal,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        action,
  output logic [2:0]        voice,
  output logic [6:0]        voice_note,
  output logic [6:0]        voice_velocity,
  output logic [8:0]        decay_scale,
  output logic signed [1:0] glide_dir,
  output logic [15:0]       glide_step,
  output logic              last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int CW = $clog2(VOICES + 1);
  localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam logic [CW-1:0] VMAX = CW'(VOICES);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_PUSHP  = 5'd1;
  localparam logic [4:0] ST_HAS    = 5'd2;
  localparam logic [4:0] ST_AFT1   = 5'd3;
  localparam logic [4:0] ST_FREE   = 5'd4;
  localparam logic [4:0] ST_STEAL  = 5'd5;
  localparam logic [4:0] ST_STEAL2 = 5'd6;
  localparam logic [4:0] ST_STEAL3 = 5'd7;
  localparam logic [4:0] ST_STOP   = 5'd8;
  localparam logic [4:0] ST_STOP2  = 5'd9;
  localparam logic [4:0] ST_START  = 5'd10;
  localparam logic [4:0] ST_EMITG  = 5'd11;
  localparam logic [4:0] ST_GLIDE  = 5'd12;
  localparam logic [4:0] ST_DIVW   = 5'd13;
  localparam logic [4:0] ST_GCONT  = 5'd14;
  localparam logic [4:0] ST_OFF1   = 5'd15;
  localparam logic [4:0] ST_OFF2   = 5'd16;
  localparam logic [4:0] ST_OFF3   = 5'd17;
  localparam logic [4:0] ST_ALL    = 5'd18;
  localparam logic [4:0] ST_DEL    = 5'd19;
  localparam logic [4:0] ST_SHIFT  = 5'd20;
  localparam logic [4:0] ST_FINDV  = 5'd21;
  localparam logic [4:0] ST_FIN    = 5'd22;

  localparam logic STK_P = 1'b0;
  localparam logic STK_S = 1'b1;

  logic [4:0]         state;
  logic [4:0]         ret;
  logic [4:0]         sret;
  logic [CW-1:0]      idx;
  logic [IW-1:0]      ix;
  logic [1:0]         op_r;
  logic [6:0]         note_r;
  logic [6:0]         vel_r;
  logic [6:0]         snote;
  logic [IW-1:0]      vsel;
  logic [6:0]         dval;
  logic               dsel;
  logic [IW-1:0]      dpos;
  logic [6:0]         prev;
  logic               prev_ok;
  logic [6:0]         fval;
  logic               fnd;
  logic [IW-1:0]      fidx;

  logic [6:0]         pstk [VOICES];
  logic [6:0]         sstk [VOICES];
  logic [CW-1:0]      pcnt;
  logic [CW-1:0]      scnt;
  logic [6:0]         vnote [VOICES];
  logic [VOICES-1:0]  vbusy;
  logic               sustain;
  logic [6:0]         gpos;
  logic               gvalid;
  logic [1:0]         gdir;
  logic [15:0]        gstep;
  logic               porta;
  logic [11:0]        gtime;
  logic               vscale;

  logic               cfg_wr;
  logic               in_acc;
  logic               rb_busy;
  logic               rb_start;
  pva_pkg::rb_wr_t    rb_wr;
  logic [6:0]         scan_ent;
  logic [6:0]         scan_key;
  logic               hit;
  logic [CW-1:0]      dcnt;
  logic               start_ok;
  logic               jump;
  logic [6:0]         gdiff;
  logic               div_start;
  logic               div_busy;
  logic               div_done;
  logic [pva_pkg::DIV_W-1:0] div_q;
  logic [4:0]         vsel_w;
  logic [4:0]         ix_w;

  assign ix       = idx[IW-1:0];
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign in_ready = (state == ST_IDLE) && !rb_busy;
  assign in_acc   = in_valid && in_ready;
  assign glide_dir  = gdir;
  assign glide_step = gstep;
  assign rb_start   = (state == ST_FIN);
  assign dcnt       = (dsel == STK_S) ? scnt : pcnt;
  assign start_ok   = !(vbusy[vsel] && vnote[vsel] == snote);
  assign jump       = (gtime == 12'd0) || !gvalid;
  assign gdiff      = (snote > gpos) ? (snote - gpos) : (gpos - snote);
  assign div_start  = (state == ST_GLIDE) && !jump;
  assign vsel_w     = 5'(vsel);
  assign ix_w       = 5'(ix);

  // shared compare unit for the stack searches and the voice-note search
  always_comb begin
    scan_ent = vnote[ix];
    scan_key = fval;
    case (state)
      ST_HAS: begin
        scan_ent = sstk[ix];
        scan_key = note_r;
      end
      ST_DEL: begin
        scan_ent = (dsel == STK_S) ? sstk[ix] : pstk[ix];
        scan_key = dval;
      end
      default: begin
        scan_ent = vnote[ix];
        scan_key = fval;
      end
    endcase
  end
  assign hit = (scan_ent == scan_key);

  always_comb begin
    rb_wr = '0;
    case (state)
      ST_START: begin
        if (start_ok) begin
          rb_wr.we     = 1'b1;
          rb_wr.action = pva_pkg::ACT_START;
          rb_wr.voice  = vsel_w[2:0];
          rb_wr.note   = snote;
          rb_wr.vel    = vel_r;
          rb_wr.decay  = vscale ? pva_pkg::decay_of(vel_r) : 9'd256;
        end
      end
      ST_STOP2: begin
        rb_wr.we     = 1'b1;
        rb_wr.action = pva_pkg::ACT_STOP;
        rb_wr.voice  = vsel_w[2:0];
        rb_wr.note   = vbusy[vsel] ? vnote[vsel] : 7'd0;
      end
      ST_EMITG: begin
        rb_wr.we     = 1'b1;
        rb_wr.action = pva_pkg::ACT_GLIDE;
      end
      ST_ALL: begin
        if (idx != VMAX && vbusy[ix]) begin
          rb_wr.we     = 1'b1;
          rb_wr.action = pva_pkg::ACT_STOP;
          rb_wr.voice  = ix_w[2:0];
          rb_wr.note   = vnote[ix];
        end
      end
      default: rb_wr = '0;
    endcase
  end

  always_comb begin
    unique case (paddr)
      pva_pkg::ADDR_PORTA:  prdata = {31'd0, porta};
      pva_pkg::ADDR_GTIME:  prdata = {20'd0, gtime};
      pva_pkg::ADDR_VSCALE: prdata = {31'd0, vscale};
      default:              prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pcnt    <= '0;
      scnt    <= '0;
      vbusy   <= '0;
      sustain <= 1'b0;
      gvalid  <= 1'b0;
      gpos    <= '0;
      gdir    <= '0;
      gstep   <= '0;
      porta   <= 1'b0;
      gtime   <= '0;
      vscale  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr)
          pva_pkg::ADDR_PORTA:  porta  <= pwdata[0];
          pva_pkg::ADDR_GTIME:  gtime  <= pwdata[11:0];
          pva_pkg::ADDR_VSCALE: vscale <= pwdata[0];
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            op_r   <= op;
            note_r <= note;
            vel_r  <= velocity;
            snote  <= note;
            idx    <= '0;
            unique case (op)
              pva_pkg::OP_ON: state <= ST_PUSHP;
              pva_pkg::OP_OFF: begin
                dval  <= note;
                dsel  <= STK_P;
                ret   <= ST_OFF1;
                state <= ST_DEL;
              end
              pva_pkg::OP_SUS: begin
                sustain <= pedal;
                state   <= ST_FIN;
              end
              default: state <= ST_ALL;
            endcase
          end
        end
        ST_PUSHP: begin
          if (pcnt < VMAX) begin
            pstk[pcnt[IW-1:0]] <= note_r;
            pcnt <= pcnt + CW'(1);
          end
          idx <= '0;
          if (porta) state <= ST_GLIDE;
          else if (sustain) state <= ST_HAS;
          else state <= ST_FREE;
        end
        ST_HAS: begin
          if (idx >= scnt) begin
            idx   <= '0;
            state <= ST_FREE;
          end else if (hit) begin
            fval  <= note_r;
            idx   <= '0;
            ret   <= ST_AFT1;
            state <= ST_FINDV;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        ST_AFT1: begin
          idx <= '0;
          if (fnd) begin
            vsel  <= fidx;
            state <= ST_START;
          end else begin
            state <= ST_FREE;
          end
        end
        ST_FREE: begin
          if (idx == VMAX) begin
            state <= ST_STEAL;
          end else if (!vbusy[ix]) begin
            vsel  <= ix;
            state <= ST_START;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        ST_STEAL: begin
          if (scnt == '0) begin
            state <= ST_FIN;
          end else begin
            dval  <= sstk[0];
            fval  <= sstk[0];
            dsel  <= STK_P;
            idx   <= '0;
            ret   <= ST_STEAL2;
            state <= ST_DEL;
          end
        end
        ST_STEAL2: begin
          idx   <= '0;
          ret   <= ST_STEAL3;
          state <= ST_FINDV;
        end
        ST_STEAL3: begin
          if (fnd) begin
            vsel  <= fidx;
            sret  <= ST_START;
            state <= ST_STOP;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_STOP: begin
          if (vbusy[vsel]) begin
            dval  <= vnote[vsel];
            dsel  <= STK_S;
            idx   <= '0;
            ret   <= ST_STOP2;
            state <= ST_DEL;
          end else begin
            state <= ST_STOP2;
          end
        end
        ST_STOP2: begin
          vbusy[vsel] <= 1'b0;
          vnote[vsel] <= '0;
          state       <= sret;
        end
        ST_START: begin
          if (start_ok) begin
            if (scnt < VMAX) begin
              sstk[scnt[IW-1:0]] <= snote;
              scnt <= scnt + CW'(1);
            end
            vbusy[vsel] <= 1'b1;
            vnote[vsel] <= snote;
            state       <= ST_FIN;
          end else if (!porta) begin
            state <= ST_FIN;
          end else if (op_r == pva_pkg::OP_ON) begin
            state <= ST_EMITG;
          end else begin
            // legato back onto the same note: drop it from the sounding stack once more
            dval  <= note_r;
            dsel  <= STK_S;
            idx   <= '0;
            ret   <= ST_EMITG;
            state <= ST_DEL;
          end
        end
        ST_EMITG: state <= ST_FIN;
        ST_GLIDE: begin
          if (op_r == pva_pkg::OP_ON) scnt <= '0;
          if (jump) begin
            gpos   <= snote;
            gvalid <= 1'b1;
            gdir   <= 2'b00;
            state  <= ST_GCONT;
          end else begin
            gdir  <= (snote > gpos) ? 2'b01 : 2'b11;
            state <= ST_DIVW;
          end
        end
        ST_DIVW: begin
          if (div_done) begin
            gstep <= 16'(div_q);
            state <= ST_GCONT;
          end
        end
        ST_GCONT: begin
          vsel  <= '0;
          state <= ST_START;
        end
        ST_OFF1: begin
          if (sustain) begin
            state <= ST_FIN;
          end else if (porta) begin
            if (!(vbusy[0] && vnote[0] == note_r)) begin
              state <= ST_FIN;
            end else if (prev_ok) begin
              snote <= prev;
              dval  <= note_r;
              dsel  <= STK_S;
              idx   <= '0;
              ret   <= ST_GLIDE;
              state <= ST_DEL;
            end else begin
              vsel  <= '0;
              sret  <= ST_OFF2;
              state <= ST_STOP;
            end
          end else begin
            fval  <= note_r;
            idx   <= '0;
            ret   <= ST_OFF3;
            state <= ST_FINDV;
          end
        end
        ST_OFF2: begin
          gvalid <= 1'b0;
          gpos   <= '0;
          gdir   <= 2'b00;
          state  <= ST_FIN;
        end
        ST_OFF3: begin
          if (fnd) begin
            vsel  <= fidx;
            sret  <= ST_FIN;
            state <= ST_STOP;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_ALL: begin
          if (idx == VMAX) begin
            scnt  <= '0;
            state <= ST_FIN;
          end else begin
            if (vbusy[ix]) begin
              vbusy[ix] <= 1'b0;
              vnote[ix] <= '0;
            end
            idx <= idx + CW'(1);
          end
        end
        ST_DEL: begin
          if (idx >= dcnt) begin
            prev_ok <= 1'b0;
            state   <= ret;
          end else if (hit) begin
            dpos    <= ix;
            prev_ok <= (idx != '0);
            state   <= ST_SHIFT;
          end else begin
            prev <= scan_ent;
            idx  <= idx + CW'(1);
          end
        end
        ST_SHIFT: begin
          for (int k = 0; k < VOICES - 1; k++) begin
            if (IW'(k) >= dpos) begin
              if (dsel == STK_S) sstk[k] <= sstk[k+1];
              else pstk[k] <= pstk[k+1];
            end
          end
          if (dsel == STK_S) scnt <= scnt - CW'(1);
          else pcnt <= pcnt - CW'(1);
          state <= ret;
        end
        ST_FINDV: begin
          if (idx == VMAX) begin
            fnd   <= 1'b0;
            state <= ret;
          end else if (vbusy[ix] && hit) begin
            fnd   <= 1'b1;
            fidx  <= ix;
            state <= ret;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        ST_FIN: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  pva_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({gdiff, 8'd0}),
    .divisor  (gtime),
    .busy     (div_busy),
    .done     (div_done),
    .quo      (div_q)
  );

  pva_rbuf u_rbuf (
    .clk            (clk),
    .rst            (rst),
    .wr             (rb_wr),
    .start          (rb_start),
    .busy           (rb_busy),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .action         (action),
    .voice          (voice),
    .voice_note     (voice_note),
    .voice_velocity (voice_velocity),
    .decay_scale    (decay_scale),
    .last           (last)
  );

  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == ST_IDLE)
    else $error("result streaming while sequencer busy");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    pcnt <= VMAX && scnt <= VMAX)
    else $error("stack count past depth");

  a_dir_code: assert property (@(posedge clk) disable iff (rst)
    gdir != 2'b10)
    else $error("bad glide direction");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> state == ST_DIVW)
    else $error("divider running outside glide wait");

endmodule
